>>> src/pad_pkg.sv
// Shared constants and types for the polyline area decimator.
// No dependencies; used by pad_core, pad_fifo and polyline_area_decimator.
package pad_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int LIMIT_WIDTH = 34;
    localparam int FIFO_DEPTH  = 4;

    // Write strobes from the decision stage into the result queue.
    // vld1 is only ever set together with vld0.
    typedef struct packed {
        logic vld0;
        logic vld1;
    } t_wr;

endpackage

>>> src/pad_core.sv
// Decision stage: path state, cross product and threshold compare.
// Depends on pad_pkg (t_wr, LIMIT_WIDTH).
module pad_core #(
    parameter int CW = pad_pkg::COORD_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic [CW-1:0]                  i_x,
    input  logic [CW-1:0]                  i_y,
    input  logic                           i_last,
    input  logic [pad_pkg::LIMIT_WIDTH-1:0] i_limit,
    output pad_pkg::t_wr                   o_wr,
    output logic [2*CW:0]                  o_d0,   // {last, y, x}
    output logic [2*CW:0]                  o_d1    // {last, y, x}
);

    localparam int PROD_W = 2 * CW + 2;
    localparam int CROSS_W = 2 * CW + 3;
    localparam int CMP_W = (CROSS_W > pad_pkg::LIMIT_WIDTH) ? CROSS_W : pad_pkg::LIMIT_WIDTH;

    logic          r_anchor_valid, n_anchor_valid;
    logic [CW-1:0] r_anchor_x, n_anchor_x;
    logic [CW-1:0] r_anchor_y, n_anchor_y;
    logic          r_pend_valid, n_pend_valid;
    logic [CW-1:0] r_pend_x, n_pend_x;
    logic [CW-1:0] r_pend_y, n_pend_y;

    logic signed [CW:0]      dpx, dpy, dnx, dny;
    logic signed [PROD_W-1:0] prod_a, prod_b;
    logic signed [CROSS_W-1:0] cross_v;
    logic [CROSS_W-1:0]      mag;
    logic                    below;
    logic                    keep;

    // (pending - anchor) x (next - anchor)
    assign dpx = $signed({r_pend_x[CW-1], r_pend_x}) - $signed({r_anchor_x[CW-1], r_anchor_x});
    assign dpy = $signed({r_pend_y[CW-1], r_pend_y}) - $signed({r_anchor_y[CW-1], r_anchor_y});
    assign dnx = $signed({i_x[CW-1], i_x}) - $signed({r_anchor_x[CW-1], r_anchor_x});
    assign dny = $signed({i_y[CW-1], i_y}) - $signed({r_anchor_y[CW-1], r_anchor_y});
    assign prod_a = dpx * dny;
    assign prod_b = dpy * dnx;
    assign cross_v = $signed({prod_a[PROD_W-1], prod_a}) - $signed({prod_b[PROD_W-1], prod_b});
    assign mag = cross_v[CROSS_W-1] ? CROSS_W'(-cross_v) : CROSS_W'(cross_v);
    assign below = CMP_W'(mag) < CMP_W'(i_limit);
    assign keep = r_pend_valid && !below;

    always_comb begin
        n_anchor_valid = r_anchor_valid;
        n_anchor_x     = r_anchor_x;
        n_anchor_y     = r_anchor_y;
        n_pend_valid   = r_pend_valid;
        n_pend_x       = r_pend_x;
        n_pend_y       = r_pend_y;
        o_wr           = '0;
        o_d0           = {i_last, i_y, i_x};
        o_d1           = {1'b1, i_y, i_x};
        if (i_go) begin
            if (!r_anchor_valid) begin
                // first point of a path goes straight out
                o_wr.vld0    = 1'b1;
                n_pend_valid = 1'b0;
                if (!i_last) begin
                    n_anchor_valid = 1'b1;
                    n_anchor_x     = i_x;
                    n_anchor_y     = i_y;
                end
            end else begin
                if (keep) begin
                    o_d0       = {1'b0, r_pend_y, r_pend_x};
                    o_wr.vld0  = 1'b1;
                    n_anchor_x = r_pend_x;
                    n_anchor_y = r_pend_y;
                end
                if (i_last) begin
                    if (keep) begin
                        o_wr.vld1 = 1'b1;
                    end else begin
                        o_d0      = {1'b1, i_y, i_x};
                        o_wr.vld0 = 1'b1;
                    end
                    n_anchor_valid = 1'b0;
                    n_pend_valid   = 1'b0;
                end else begin
                    n_pend_valid = 1'b1;
                    n_pend_x     = i_x;
                    n_pend_y     = i_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_valid <= 1'b0;
            r_pend_valid   <= 1'b0;
        end else begin
            r_anchor_valid <= n_anchor_valid;
            r_pend_valid   <= n_pend_valid;
        end
        r_anchor_x <= n_anchor_x;
        r_anchor_y <= n_anchor_y;
        r_pend_x   <= n_pend_x;
        r_pend_y   <= n_pend_y;
    end

    // a pending point never exists without an anchor
    a_pend_needs_anchor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_anchor_valid)
        else $error("pending point without anchor");

    // end of path clears all path state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && i_last |=> !r_anchor_valid && !r_pend_valid)
        else $error("path state survived end of path");

    // a path start yields exactly one result
    a_start_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && !r_anchor_valid |-> o_wr.vld0 && !o_wr.vld1)
        else $error("path start result count wrong");

endmodule

>>> src/pad_fifo.sv
// Small result queue: takes up to two requests per cycle, releases one.
// Depends on pad_pkg (t_wr, FIFO_DEPTH).
module pad_fifo #(
    parameter int DW = 2 * pad_pkg::COORD_WIDTH + 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  pad_pkg::t_wr i_wr,
    input  logic [DW-1:0] i_d0,
    input  logic [DW-1:0] i_d1,
    output logic         o_room2,
    output logic         o_valid,
    output logic [DW-1:0] o_data,
    input  logic         i_ready
);

    localparam int DEPTH = pad_pkg::FIFO_DEPTH;
    localparam int PW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DW-1:0]   r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            pop;
    logic [PW-1:0]   wr_ptr1;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room2 = (r_cnt <= CNTW'(DEPTH - 2));
    assign wr_ptr1 = r_wr_ptr + PW'(1);

    always_comb begin
        n_cnt = r_cnt + CNTW'(i_wr.vld0) + CNTW'(i_wr.vld1) - CNTW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_wr.vld1) begin
                r_wr_ptr <= r_wr_ptr + PW'(2);
            end else if (i_wr.vld0) begin
                r_wr_ptr <= wr_ptr1;
            end
        end
        if (i_wr.vld0) begin
            r_mem[r_wr_ptr] <= i_d0;
        end
        if (i_wr.vld1) begin
            r_mem[wr_ptr1] <= i_d1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(DEPTH))
        else $error("result queue overflow");

    a_pair_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.vld1 |-> i_wr.vld0 && o_room2)
        else $error("second request without first or without room");

endmodule

>>> src/polyline_area_decimator.sv
// Top level: input register, pad_core decision stage, pad_fifo result queue.
// An accepted point is held in the input register, then its results are written to the queue.
// Throughput: one point per cycle; a point releasing two results leaves the output as two
//   transfers; input stalls while the queue holds more than two results.
// Reset (i_rst_n low, synchronous): clears area limit, path state and queue.
// Depends on pad_pkg, pad_core, pad_fifo.
module polyline_area_decimator #(
    parameter int COORD_WIDTH = pad_pkg::COORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: twice the area limit
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pad_pkg::LIMIT_WIDTH-1:0]   i_cfg_data,
    // input points
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // in_x, in_y, zero pad
    input  logic                              s_axis_tlast,   // in_last
    // kept points
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,  // out_x, out_y, zero pad
    output logic                              m_axis_tlast    // out_last
);

    localparam int CW = COORD_WIDTH;
    localparam int TDW = ((2 * CW + 7) / 8) * 8;
    localparam int DW = 2 * CW + 1;

    // configuration register, always ready
    logic [pad_pkg::LIMIT_WIDTH-1:0] r_limit;

    // input register stage
    logic          r_in_valid;
    logic [CW-1:0] r_in_x;
    logic [CW-1:0] r_in_y;
    logic          r_in_last;

    logic          go;
    logic          room2;
    pad_pkg::t_wr  wr;
    logic [DW-1:0] d0, d1;
    logic [DW-1:0] q_data;

    assign o_cfg_ready = 1'b1;

    // decision fires when the queue can take the worst case of two results
    assign go            = r_in_valid && room2;
    assign s_axis_tready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= '0;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_x    <= s_axis_tdata[CW-1:0];
            r_in_y    <= s_axis_tdata[2*CW-1:CW];
            r_in_last <= s_axis_tlast;
        end
    end

    pad_core #(
        .CW (CW)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_x     (r_in_x),
        .i_y     (r_in_y),
        .i_last  (r_in_last),
        .i_limit (r_limit),
        .o_wr    (wr),
        .o_d0    (d0),
        .o_d1    (d1)
    );

    pad_fifo #(
        .DW (DW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_d0    (d0),
        .i_d1    (d1),
        .o_room2 (room2),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = TDW'(q_data[2*CW-1:0]);
    assign m_axis_tlast = q_data[2*CW];

    // a held input request is never dropped while the queue lacks room for two results
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !room2 |=> r_in_valid && $stable(r_in_x) && $stable(r_in_y))
        else $error("input request lost while stalled");

    // results only appear after a decision
    a_out_from_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.vld0 |-> go)
        else $error("result written without decision");

endmodule

>>> bench/tb.sv
// Self-checking bench for polyline_area_decimator: predicts kept points per request
// and checks every output request in order. Depends on pad_pkg and the src/ RTL.
`timescale 1ns / 100ps

module tb;

    localparam int  CW          = pad_pkg::COORD_WIDTH;
    localparam int  LW          = pad_pkg::LIMIT_WIDTH;
    localparam int  DRAIN_WAIT  = 8;        // settle cycles after the last result
    localparam int  CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } t_kept_pt;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LW-1:0]        i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [2*CW-1:0]      s_axis_tdata = '0;    // in_x, in_y
    logic                 s_axis_tlast = 1'b0;  // in_last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [2*CW-1:0]      m_axis_tdata;         // out_x, out_y
    logic                 m_axis_tlast;         // out_last

    polyline_area_decimator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [LW-1:0]        area_limit = '0;
    logic                 anchor_on = 1'b0;
    logic signed [CW-1:0] anchor_x = '0;
    logic signed [CW-1:0] anchor_y = '0;
    logic                 cand_on = 1'b0;
    logic signed [CW-1:0] cand_x = '0;
    logic signed [CW-1:0] cand_y = '0;

    t_kept_pt kept_q[$];
    int       err_cnt = 0;
    int       cycle_cnt = 0;
    int       sender_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_left = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    function automatic t_kept_pt mk_pt(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                       logic last);
        t_kept_pt p;
        p.x = x;
        p.y = y;
        p.last = last;
        return p;
    endfunction

    // Greedy decimation: the candidate is tested against the anchor and the new point.
    task automatic predict_kept(logic signed [CW-1:0] nx, logic signed [CW-1:0] ny,
                                logic last);
        longint dpx, dpy, dnx, dny, c;
        longint unsigned mag;
        if (!anchor_on) begin
            kept_q.push_back(mk_pt(nx, ny, last));
            if (!last) begin
                anchor_on = 1'b1;
                anchor_x  = nx;
                anchor_y  = ny;
            end
            cand_on = 1'b0;
        end else begin
            if (cand_on) begin
                dpx = longint'(cand_x) - longint'(anchor_x);
                dpy = longint'(cand_y) - longint'(anchor_y);
                dnx = longint'(nx) - longint'(anchor_x);
                dny = longint'(ny) - longint'(anchor_y);
                c   = dpx * dny - dpy * dnx;
                mag = (c < 0) ? longint'(-c) : c;
                if (!(mag < longint'(area_limit))) begin
                    kept_q.push_back(mk_pt(cand_x, cand_y, 1'b0));
                    anchor_x = cand_x;
                    anchor_y = cand_y;
                end
                cand_on = 1'b0;
            end
            if (last) begin
                kept_q.push_back(mk_pt(nx, ny, 1'b1));
                anchor_on = 1'b0;
                cand_on   = 1'b0;
            end else begin
                cand_on = 1'b1;
                cand_x  = nx;
                cand_y  = ny;
            end
        end
    endtask

    // One point request; tvalid stays high afterwards so back-to-back requests need no gap.
    task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_kept(x, y, last);
    endtask

    // Stop sending, wait for every expected point, then let the pipeline settle.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_area_limit(logic [LW-1:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        area_limit = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off when a test asks for one
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_kept_pt want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (kept_q.size() == 0) begin
                report_mismatch("unexpected point x", int'($signed(m_axis_tdata[CW-1:0])), 0);
            end else begin
                want = kept_q.pop_front();
                if (m_axis_tdata[CW-1:0] !== want.x)
                    report_mismatch("out_x", int'($signed(m_axis_tdata[CW-1:0])),
                                    int'(want.x));
                if (m_axis_tdata[2*CW-1:CW] !== want.y)
                    report_mismatch("out_y", int'($signed(m_axis_tdata[2*CW-1:CW])),
                                    int'(want.y));
                if (m_axis_tlast !== want.last)
                    report_mismatch("out_last", int'(m_axis_tlast), int'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("polyline_area_decimator regression: fail");
            $finish;
        end
    end

    // ---------------- directed tests ----------------

    task automatic test_single_point();
        set_area_limit('0);
        send_point(-16'sd32768, 16'sd32767, 1'b1);
    endtask

    task automatic test_two_point();
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
    endtask

    // zero limit: the middle point is kept and the end releases two points
    task automatic test_pending_then_end();
        send_point(16'sd1, 16'sd2, 1'b0);
        send_point(16'sd3, -16'sd4, 1'b0);
        send_point(16'sd5, 16'sd6, 1'b1);
    endtask

    task automatic test_collinear_dropped();
        set_area_limit(34'd1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd1, 16'sd1, 1'b0);
        send_point(16'sd3, 16'sd3, 1'b0);
        send_point(16'sd3, 16'sd3, 1'b0);
        send_point(16'sd10, 16'sd0, 1'b1);
    endtask

    // corner-to-corner triangles at the edge of the compare, then the full 34-bit limit
    task automatic test_extreme_corners();
        set_area_limit(34'd4294836225);     // 65535 * 65535
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b1);   // equal to limit: kept
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32766, 1'b1);   // just below: dropped
        set_area_limit({LW{1'b1}});
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b1);
    endtask

    // ---------------- random tests ----------------

    // Random open paths: small-step walks (or full-range jumps), some coincident points.
    task automatic test_random_paths(int n_items, int step, bit full_range);
        int sent, len, cx, cy;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            cx  = int'($signed(16'($urandom)));
            cy  = int'($signed(16'($urandom)));
            for (int i = 0; i < len; i++) begin
                if (i != 0 && $urandom_range(9) != 0) begin
                    if (full_range) begin
                        cx = int'($signed(16'($urandom)));
                        cy = int'($signed(16'($urandom)));
                    end else begin
                        cx += int'($urandom_range(0, 2 * step)) - step;
                        cy += int'($urandom_range(0, 2 * step)) - step;
                        if (cx > 32767) cx = 32767;
                        if (cx < -32768) cx = -32768;
                        if (cy > 32767) cy = 32767;
                        if (cy < -32768) cy = -32768;
                    end
                end
                send_point(16'(cx), 16'(cy), i == len - 1);
                sent++;
            end
        end
    endtask

    // Long receiver hold-off while points keep coming: the queue fills, input must stall.
    task automatic test_output_stall();
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        set_area_limit('0);
        hold_left = 300;
        test_random_paths(60, 64, 1'b0);
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_point();
        test_two_point();
        test_pending_then_end();
        test_collinear_dropped();
        test_extreme_corners();
        test_output_stall();

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin sender_idle_pct = 20; recv_idle_pct = 79; end
                1: begin sender_idle_pct = 79; recv_idle_pct = 20; end
                default: begin sender_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            set_area_limit(34'($urandom_range(0, 6000)));
            test_random_paths(180, 64, 1'b0);
            set_area_limit(34'($urandom_range(0, 300)));
            test_random_paths(180, 16, 1'b0);
            set_area_limit({1'b0, 1'($urandom), 32'($urandom)});
            test_random_paths(20, 0, 1'b1);
        end

        set_area_limit(34'h2_0000_0000);    // 2^33, above the largest cross product magnitude
        test_random_paths(20, 0, 1'b1);

        wait_idle();
        if (err_cnt == 0) begin
            $display("polyline_area_decimator regression: pass");
        end else begin
            $display("polyline_area_decimator regression: fail");
        end
        $finish;
    end

endmodule
